/* src/cbp_pkg.sv */
`default_nettype none
package cbp_pkg;

  localparam int CW   = 24;
  localparam int GB   = 4;
  localparam int XW   = CW + 4;
  localparam int MW   = CW + 1;
  localparam int D2W  = 2 * MW + 1;
  localparam int NW   = D2W + 2 * GB;
  localparam int NPW  = NW + (NW % 2);
  localparam int QW   = NPW / 2;
  localparam int RW   = QW + 2;
  localparam int PW   = MW + QW;
  localparam int NUMW = PW + 1;
  localparam int QTW  = QW - GB + 1;
  localparam int LAT  = QW + QTW + 8;

  typedef enum logic [2:0] {
    SIDE_BOTTOM = 3'd0,
    SIDE_TOP    = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_LEFT   = 3'd3,
    SIDE_CORNER = 3'd4
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] box_left;
    logic signed [CW-1:0] box_top;
    logic        [CW-2:0] box_width;
    logic        [CW-2:0] box_height;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [CW-2:0] radius;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] new_x;
    logic signed [CW-1:0] new_y;
    side_t                side_hit;
  } out_t;

  typedef struct packed {
    logic                 corner;
    side_t                side;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [MW-1:0] mx;
    logic        [MW-1:0] my;
    logic                 sx;
    logic                 sy;
    logic        [CW-2:0] r;
  } ctx_t;

endpackage
`default_nettype wire

/* src/circle_box_push_out.sv */
// circle_box_push_out
// pushes a circle out of an axis-aligned box; positions are signed Q16.8 pixels, sizes and radius unsigned Q15.8
//
// input channel: in_item is taken at a rising edge with start high and busy low.
// busy is never raised, so one item can be started in every cycle.
// result channel: out_item is valid for exactly one cycle while out_valid is
// high; the receiver has no way to hold results back and needs none.
//
// widths: QW = 30 root bits and QTW = 27 quotient bits.
// throughput: one item per cycle; the depth is set by the root pipeline,
// one root bit per stage, and the two dividers, one quotient bit per stage.
// edge and corner items travel the same pipeline, so results keep input order.
//
// reset: synchronous, active low; it clears every stage valid bit, so no
// result is given for items in flight when reset is asserted.
`default_nettype none
module circle_box_push_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire cbp_pkg::in_t  in_item,
  output logic               out_valid,
  output cbp_pkg::out_t      out_item
);

  localparam int CW   = cbp_pkg::CW;
  localparam int GB   = cbp_pkg::GB;
  localparam int XW   = cbp_pkg::XW;
  localparam int MW   = cbp_pkg::MW;
  localparam int D2W  = cbp_pkg::D2W;
  localparam int NPW  = cbp_pkg::NPW;
  localparam int QW   = cbp_pkg::QW;
  localparam int RW   = cbp_pkg::RW;
  localparam int PW   = cbp_pkg::PW;
  localparam int NUMW = cbp_pkg::NUMW;
  localparam int QTW  = cbp_pkg::QTW;

  function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    lo = -hi - XW'(1);
    if (v > hi) begin
      sat = hi[CW-1:0];
    end else if (v < lo) begin
      sat = lo[CW-1:0];
    end else begin
      sat = v[CW-1:0];
    end
  endfunction

  assign busy = 1'b0;

  // input register
  logic         v0_r;
  cbp_pkg::in_t in0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    in0_r <= in_item;
  end

  // classify, edge results, corner deltas
  logic          v1_r;
  cbp_pkg::ctx_t ctx1_r;
  cbp_pkg::ctx_t ctx1_nxt;

  always_comb begin
    logic signed [XW-1:0] l, t, rt, bt, cx, cy, rr, kx, ky, dx, dy;
    logic                 in_x, in_y;
    l  = XW'(in0_r.box_left);
    t  = XW'(in0_r.box_top);
    cx = XW'(in0_r.center_x);
    cy = XW'(in0_r.center_y);
    rr = XW'(in0_r.radius);
    rt = l + XW'(in0_r.box_width);
    bt = t + XW'(in0_r.box_height);
    in_x = (cx >= l) && (cx <= rt);
    in_y = (cy >= t) && (cy <= bt);
    kx = (cx > rt) ? rt : l;
    ky = (cy > bt) ? bt : t;
    dx = cx - kx;
    dy = cy - ky;
    ctx1_nxt.cx     = in0_r.center_x;
    ctx1_nxt.cy     = in0_r.center_y;
    ctx1_nxt.r      = in0_r.radius;
    ctx1_nxt.sx     = dx[XW-1];
    ctx1_nxt.sy     = dy[XW-1];
    ctx1_nxt.mx     = MW'(dx[XW-1] ? -dx : dx);
    ctx1_nxt.my     = MW'(dy[XW-1] ? -dy : dy);
    ctx1_nxt.corner = 1'b0;
    ctx1_nxt.ex     = in0_r.center_x;
    ctx1_nxt.ey     = in0_r.center_y;
    if (in_x) begin
      if (cy >= bt) begin
        ctx1_nxt.ey   = sat(bt + rr);
        ctx1_nxt.side = cbp_pkg::SIDE_BOTTOM;
      end else begin
        ctx1_nxt.ey   = sat(t - rr);
        ctx1_nxt.side = cbp_pkg::SIDE_TOP;
      end
    end else if (in_y) begin
      if (cx >= rt) begin
        ctx1_nxt.ex   = sat(rt + rr);
        ctx1_nxt.side = cbp_pkg::SIDE_RIGHT;
      end else begin
        ctx1_nxt.ex   = sat(l - rr);
        ctx1_nxt.side = cbp_pkg::SIDE_LEFT;
      end
    end else begin
      ctx1_nxt.corner = 1'b1;
      ctx1_nxt.side   = cbp_pkg::SIDE_CORNER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    ctx1_r <= ctx1_nxt;
  end

  // squares
  logic            v2_r;
  cbp_pkg::ctx_t   ctx2_r;
  logic [2*MW-1:0] xx2_r, yy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    ctx2_r <= ctx1_r;
    xx2_r  <= ctx1_r.mx * ctx1_r.mx;
    yy2_r  <= ctx1_r.my * ctx1_r.my;
  end

  // root pipeline, stage 0 holds the scaled squared distance
  logic                 sv_r    [0:QW];
  cbp_pkg::ctx_t        sctx_r  [0:QW];
  logic [NPW-1:0]       sn_r    [0:QW];
  logic [RW-1:0]        srem_r  [0:QW];
  logic [QW-1:0]        sroot_r [0:QW];
  logic [D2W-1:0]       d2_nxt;

  assign d2_nxt = D2W'(xx2_r) + D2W'(yy2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= v2_r;
    end
    sctx_r[0]  <= ctx2_r;
    sn_r[0]    <= NPW'(d2_nxt) << (2 * GB);
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
  end

  logic [RW-1:0] srem_nxt  [1:QW];
  logic [QW-1:0] sroot_nxt [1:QW];

  for (genvar i = 1; i <= QW; i++) begin : g_root
    always_comb begin
      logic [RW-1:0] rt;
      logic [RW-1:0] trial;
      rt    = {srem_r[i-1][RW-3:0], sn_r[i-1][NPW-1 -: 2]};
      trial = {sroot_r[i-1], 2'b01};
      if (rt >= trial) begin
        srem_nxt[i]  = rt - trial;
        sroot_nxt[i] = {sroot_r[i-1][QW-2:0], 1'b1};
      end else begin
        srem_nxt[i]  = rt;
        sroot_nxt[i] = {sroot_r[i-1][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else begin
        sv_r[i] <= sv_r[i-1];
      end
      sctx_r[i]  <= sctx_r[i-1];
      sn_r[i]    <= sn_r[i-1] << 2;
      srem_r[i]  <= srem_nxt[i];
      sroot_r[i] <= sroot_nxt[i];
    end
  end

  // distance error, products, rounding term
  logic          vs_r, vm_r;
  cbp_pkg::ctx_t ctxs_r, ctxm_r;
  logic [QW-1:0] dqs_r, sqs_r, dqm_r;
  logic [PW-1:0] pxm_r, pym_r;
  logic [QW-1:0] rq;

  assign rq = QW'({sctx_r[QW].r, {GB{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
      vm_r <= 1'b0;
    end else begin
      vs_r <= sv_r[QW];
      vm_r <= vs_r;
    end
    ctxs_r <= sctx_r[QW];
    dqs_r  <= sroot_r[QW];
    sqs_r  <= (sroot_r[QW] >= rq) ? sroot_r[QW] - rq : rq - sroot_r[QW];
    ctxm_r <= ctxs_r;
    dqm_r  <= dqs_r;
    pxm_r  <= PW'(ctxs_r.mx * sqs_r);
    pym_r  <= PW'(ctxs_r.my * sqs_r);
  end

  // divider pipelines, stage 0 holds the rounded numerators
  logic           dv_r   [0:QTW];
  cbp_pkg::ctx_t  dctx_r [0:QTW];
  logic [QW-1:0]  ddq_r  [0:QTW];
  logic [QW-1:0]  drx_r  [0:QTW];
  logic [QW-1:0]  dry_r  [0:QTW];
  logic [QTW-1:0] dnx_r  [0:QTW];
  logic [QTW-1:0] dny_r  [0:QTW];
  logic [NUMW-1:0] numx, numy;

  assign numx = NUMW'(pxm_r) + NUMW'(dqm_r >> 1);
  assign numy = NUMW'(pym_r) + NUMW'(dqm_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= vm_r;
    end
    dctx_r[0] <= ctxm_r;
    ddq_r[0]  <= dqm_r;
    drx_r[0]  <= QW'(numx >> QTW);
    dry_r[0]  <= QW'(numy >> QTW);
    dnx_r[0]  <= numx[QTW-1:0];
    dny_r[0]  <= numy[QTW-1:0];
  end

  logic [QW-1:0]  drx_nxt [1:QTW];
  logic [QW-1:0]  dry_nxt [1:QTW];
  logic [QTW-1:0] dnx_nxt [1:QTW];
  logic [QTW-1:0] dny_nxt [1:QTW];

  for (genvar j = 1; j <= QTW; j++) begin : g_div
    always_comb begin
      logic [QW:0] tx;
      logic [QW:0] ty;
      tx = {drx_r[j-1], dnx_r[j-1][QTW-1]};
      ty = {dry_r[j-1], dny_r[j-1][QTW-1]};
      if (tx >= {1'b0, ddq_r[j-1]}) begin
        drx_nxt[j] = QW'(tx - {1'b0, ddq_r[j-1]});
        dnx_nxt[j] = {dnx_r[j-1][QTW-2:0], 1'b1};
      end else begin
        drx_nxt[j] = tx[QW-1:0];
        dnx_nxt[j] = {dnx_r[j-1][QTW-2:0], 1'b0};
      end
      if (ty >= {1'b0, ddq_r[j-1]}) begin
        dry_nxt[j] = QW'(ty - {1'b0, ddq_r[j-1]});
        dny_nxt[j] = {dny_r[j-1][QTW-2:0], 1'b1};
      end else begin
        dry_nxt[j] = ty[QW-1:0];
        dny_nxt[j] = {dny_r[j-1][QTW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else begin
        dv_r[j] <= dv_r[j-1];
      end
      dctx_r[j] <= dctx_r[j-1];
      ddq_r[j]  <= ddq_r[j-1];
      drx_r[j]  <= drx_nxt[j];
      dry_r[j]  <= dry_nxt[j];
      dnx_r[j]  <= dnx_nxt[j];
      dny_r[j]  <= dny_nxt[j];
    end
  end

  // apply offsets, saturate, pick result
  logic          out_valid_r;
  cbp_pkg::out_t out_item_r;
  cbp_pkg::out_t out_item_nxt;

  always_comb begin
    logic signed [XW-1:0] qx, qy;
    cbp_pkg::ctx_t        c;
    c  = dctx_r[QTW];
    qx = $signed({{(XW-QTW){1'b0}}, dnx_r[QTW]});
    qy = $signed({{(XW-QTW){1'b0}}, dny_r[QTW]});
    out_item_nxt.side_hit = c.side;
    if (c.corner) begin
      out_item_nxt.new_x = sat(XW'(c.cx) + (c.sx ? -qx : qx));
      out_item_nxt.new_y = sat(XW'(c.cy) + (c.sy ? -qy : qy));
    end else begin
      out_item_nxt.new_x = c.ex;
      out_item_nxt.new_y = c.ey;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[QTW];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cbp_pkg::LAT) out_valid)
    else $error("item lost in pipeline");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, cbp_pkg::LAT))
    else $error("result without item");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[QTW] && dctx_r[QTW].corner) |-> (drx_r[QTW] < ddq_r[QTW]
      && dry_r[QTW] < ddq_r[QTW]))
    else $error("divider remainder out of range");

  a_dq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (vs_r && ctxs_r.corner) |-> (dqs_r != '0))
    else $error("zero corner distance");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = cbp_pkg::CW;
  localparam int GB = cbp_pkg::GB;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = cbp_pkg::LAT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cbp_pkg::in_t in_item = '0;
  logic out_valid;
  cbp_pkg::out_t out_item;

  circle_box_push_out dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  cbp_pkg::in_t pending_items[$];
  int pending_gaps[$];
  cbp_pkg::out_t expected_pushes[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  int gap_left = 0;
  bit drain_hold = 1'b0;
  int hold_index = -1;
  int sent = 0;

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -(longint'(1) <<< (CW - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_offset(longint delta, longint unsigned sq,
                                          longint unsigned dq);
    longint unsigned mag, q;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    q = (mag * sq + dq / 2) / dq;
    return (delta < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic cbp_pkg::out_t push_out(cbp_pkg::in_t it);
    longint l, t, w, h, cx, cy, r, rt, bt, nx, ny, kx, ky, dx, dy;
    longint unsigned d2, dq, rq, sq;
    cbp_pkg::side_t side;
    cbp_pkg::out_t o;
    l = longint'(it.box_left);
    t = longint'(it.box_top);
    w = longint'({1'b0, it.box_width});
    h = longint'({1'b0, it.box_height});
    cx = longint'(it.center_x);
    cy = longint'(it.center_y);
    r = longint'({1'b0, it.radius});
    rt = l + w;
    bt = t + h;
    if (cx >= l && cx <= rt) begin
      nx = cx;
      if (cy >= bt) begin
        ny = bt + r;
        side = cbp_pkg::SIDE_BOTTOM;
      end else begin
        ny = t - r;
        side = cbp_pkg::SIDE_TOP;
      end
    end else if (cy >= t && cy <= bt) begin
      ny = cy;
      if (cx >= rt) begin
        nx = rt + r;
        side = cbp_pkg::SIDE_RIGHT;
      end else begin
        nx = l - r;
        side = cbp_pkg::SIDE_LEFT;
      end
    end else begin
      kx = (cx > rt) ? rt : l;
      ky = (cy > bt) ? bt : t;
      dx = cx - kx;
      dy = cy - ky;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      dq = isqrt(d2 << (2 * GB));
      rq = longint'(r) << GB;
      sq = (dq >= rq) ? dq - rq : rq - dq;
      if (dq == 0) dq = 1;
      nx = cx + scale_offset(dx, sq, dq);
      ny = cy + scale_offset(dy, sq, dq);
      side = cbp_pkg::SIDE_CORNER;
    end
    o.new_x = CW'(clamp_coord(nx));
    o.new_y = CW'(clamp_coord(ny));
    o.side_hit = side;
    return o;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($urandom_range(0, 4000)) - CW'(2000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-2:0] rand_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return (CW-1)'($urandom_range(0, 1500));
      default: return (CW-1)'($urandom);
    endcase
  endfunction

  task automatic add_item(cbp_pkg::in_t it);
    pending_items.push_back(it);
    pending_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
  endtask

  function automatic cbp_pkg::in_t near_item();
    cbp_pkg::in_t it;
    it.box_left = CW'($urandom_range(0, 2000)) - CW'(1000);
    it.box_top = CW'($urandom_range(0, 2000)) - CW'(1000);
    it.box_width = (CW-1)'($urandom_range(0, 800));
    it.box_height = (CW-1)'($urandom_range(0, 800));
    it.center_x = it.box_left + CW'($urandom_range(0, 2400)) - CW'(800);
    it.center_y = it.box_top + CW'($urandom_range(0, 2400)) - CW'(800);
    it.radius = (CW-1)'($urandom_range(0, 600));
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_pushes.push_back(push_out(in_item));
        sent++;
      end
      if (start && busy) begin
      end else if (drain_hold && expected_pushes.size() != 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        if (sent == hold_index && !drain_hold) begin
          drain_hold <= 1'b1;
          start <= 1'b0;
        end else begin
          drain_hold <= 1'b0;
          in_item <= pending_items.pop_front();
          gap_left <= pending_gaps.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        cbp_pkg::out_t e;
        if (expected_pushes.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          e = expected_pushes.pop_front();
          if (out_item.new_x !== e.new_x) begin
            $error("new_x expected %0d actual %0d", e.new_x, out_item.new_x);
            errors++;
          end
          if (out_item.new_y !== e.new_y) begin
            $error("new_y expected %0d actual %0d", e.new_y, out_item.new_y);
            errors++;
          end
          if (out_item.side_hit !== e.side_hit) begin
            $error("side_hit expected %0d actual %0d", e.side_hit, out_item.side_hit);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    cbp_pkg::in_t it;
    int i;
    it = '0;
    add_item(it);
    it.box_left = {1'b1, {(CW-1){1'b0}}};
    it.box_top = {1'b1, {(CW-1){1'b0}}};
    it.box_width = '1;
    it.box_height = '1;
    it.center_x = {1'b0, {(CW-1){1'b1}}};
    it.center_y = {1'b0, {(CW-1){1'b1}}};
    it.radius = '1;
    add_item(it);
    it.box_left = {1'b0, {(CW-1){1'b1}}};
    it.box_top = {1'b0, {(CW-1){1'b1}}};
    add_item(it);
    it.center_x = {1'b1, {(CW-1){1'b0}}};
    it.center_y = {1'b1, {(CW-1){1'b0}}};
    add_item(it);
    it.box_left = 0; it.box_top = 0; it.box_width = 256; it.box_height = 256;
    it.radius = 100;
    it.center_x = 128; it.center_y = 300; add_item(it);
    it.center_y = 256; add_item(it);
    it.center_y = 10; add_item(it);
    it.center_x = 300; it.center_y = 128; add_item(it);
    it.center_x = 256; it.center_y = 128; add_item(it);
    it.center_x = 256; it.center_y = 256; add_item(it);
    it.center_x = -40; it.center_y = 128; add_item(it);
    it.center_x = 300; it.center_y = 300; add_item(it);
    it.center_x = -30; it.center_y = -40; add_item(it);
    it.center_x = 257; it.center_y = -1; add_item(it);
    it.center_x = -1; it.center_y = 257; it.radius = 0; add_item(it);
    it.box_width = 0; it.box_height = 0; it.center_x = 0; it.center_y = 0;
    add_item(it);
    it.center_x = 1; it.center_y = 1; add_item(it);
    it.center_x = -5000; it.center_y = 7000; it.radius = '1; add_item(it);
    it.center_x = {1'b0, {(CW-1){1'b1}}}; it.center_y = {1'b1, {(CW-1){1'b0}}};
    it.box_left = 0; it.box_top = 0; it.radius = '1; add_item(it);
    for (i = 0; i < 1800; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        it = near_item();
      end else begin
        it.box_left = rand_coord();
        it.box_top = rand_coord();
        it.box_width = rand_size();
        it.box_height = rand_size();
        it.center_x = rand_coord();
        it.center_y = rand_coord();
        it.radius = rand_size();
      end
      add_item(it);
    end
    hold_index = 900;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int tail;
    tail = 0;
    while (1) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
      if (stim_done && expected_pushes.size() == 0) begin
        tail++;
        if (tail >= DRAIN) break;
      end
    end
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
